// File: rtl/wssh_pkg.sv
`default_nettype none

package wssh_pkg;

  localparam int unsigned WORD_W = 32;

  localparam logic [WORD_W-1:0] CRC32C_POLY = 32'h82F6_3B78;
  localparam logic [WORD_W-1:0] FNV_PRIME   = 32'd16777619;
  localparam logic [WORD_W-1:0] SEED_RESET  = 32'd2166136261;

  localparam logic USE_CRC_RESET = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_USE_CRC_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED_VALUE   = 1'b1;

  typedef struct packed {
    logic              use_crc_mode;
    logic [WORD_W-1:0] seed_value;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic [WORD_W-1:0] word;
  } item_t;

  // Column of the 32-step reflected CRC-32C update matrix for one input bit.
  // Only ever called with constant arguments, so it folds away at elaboration.
  function automatic logic [WORD_W-1:0] crc_col(input int unsigned idx);
    logic [WORD_W-1:0] v;
    v = '0;
    v[idx] = 1'b1;
    for (int unsigned k = 0; k < WORD_W; k++) begin
      if (v[0]) begin
        v = (v >> 1) ^ CRC32C_POLY;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/word_stream_state_hash_unit.sv
// A record's last word passes the input register, then its hash is registered onto out_tdata.
// Throughput: one word per cycle but for the stall below; the running-hash loop is one register.
// A full result register stalls only the last word of the next record, not the words before it.
// Reset (rst_n low at a clock edge) empties both stages, selects CRC mode and loads the
// default seed into both the seed register and the running hash.
`default_nettype none

module word_stream_state_hash_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Input stream.
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [31:0]                     in_tdata,   // [31:0] data_word
  input  wire logic                            in_tlast,   // end_of_record
  // Result stream.
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [31:0]                          out_tdata,  // [31:0] hash_value
  // Configuration writes.
  input  wire logic                            cfg_wr_en,
  input  wire logic [wssh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [31:0]                     cfg_wdata
);

  wssh_pkg::cfg_t  cfg;
  wssh_pkg::item_t item;
  logic            advance;

  // Mode and seed registers. The user writes them only while no word is in flight; the block
  // does not enforce it. A record may be open; the new seed applies from the next record on.
  wssh_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input register: takes a new transfer when empty or when its word moves on in the same cycle.
  wssh_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_word  (in_tdata),
    .in_last  (in_tlast),
    .advance  (advance),
    .item     (item)
  );

  // Fold stage: parallel CRC-32C or multiply-xor into the running hash, then the
  // result register that holds a finished hash until the sink takes it.
  wssh_fold u_fold (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .item      (item),
    .advance   (advance),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_hash  (out_tdata)
  );

endmodule

`default_nettype wire

// File: rtl/wssh_cfg.sv
`default_nettype none

module wssh_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [wssh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [wssh_pkg::WORD_W-1:0]     cfg_wdata,
  output wssh_pkg::cfg_t                       cfg
);

  logic                        use_crc_r, use_crc_nxt;
  logic [wssh_pkg::WORD_W-1:0] seed_r, seed_nxt;

  always_comb begin
    use_crc_nxt = use_crc_r;
    seed_nxt    = seed_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        wssh_pkg::REG_USE_CRC_MODE: use_crc_nxt = cfg_wdata[0];
        wssh_pkg::REG_SEED_VALUE:   seed_nxt    = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_crc_r <= wssh_pkg::USE_CRC_RESET;
      seed_r    <= wssh_pkg::SEED_RESET;
    end else begin
      use_crc_r <= use_crc_nxt;
      seed_r    <= seed_nxt;
    end
  end

  assign cfg.use_crc_mode = use_crc_r;
  assign cfg.seed_value   = seed_r;

endmodule

`default_nettype wire

// File: rtl/wssh_in_stage.sv
`default_nettype none

module wssh_in_stage (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [wssh_pkg::WORD_W-1:0] in_word,
  input  wire logic                        in_last,
  input  wire logic                        advance,
  output wssh_pkg::item_t                  item
);

  logic                        valid_r, valid_nxt;
  logic                        last_r;
  logic [wssh_pkg::WORD_W-1:0] word_r;

  // The register frees up in the same cycle that its word moves on.
  assign in_ready  = !valid_r || advance;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= in_word;
      last_r <= in_last;
    end
  end

  assign item.valid = valid_r;
  assign item.last  = last_r;
  assign item.word  = word_r;

endmodule

`default_nettype wire

// File: rtl/wssh_fold.sv
`default_nettype none

module wssh_fold (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wssh_pkg::cfg_t                   cfg,
  input  wssh_pkg::item_t                  item,
  output logic                             advance,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [wssh_pkg::WORD_W-1:0]      out_hash
);

  localparam int unsigned W = wssh_pkg::WORD_W;

  logic         mid_r, mid_nxt;
  logic [W-1:0] run_r, run_nxt;
  logic         oval_r, oval_nxt;
  logic [W-1:0] ohash_r;

  logic         out_free;
  logic [W-1:0] base;
  logic [W-1:0] crc_in;
  logic [W-1:0] crc_terms [W];
  logic [W-1:0] crc_out;
  logic [W-1:0] mul_out;
  logic [W-1:0] fold;

  assign out_free = !oval_r || out_ready;
  // A word that ends no record never needs the result register.
  assign advance  = item.valid && (!item.last || out_free);

  assign base   = mid_r ? run_r : cfg.seed_value;
  assign crc_in = base ^ item.word;

  // The 32 shift steps of the CRC collapse into one XOR matrix.
  for (genvar gi = 0; gi < W; gi++) begin : g_crc
    localparam logic [W-1:0] COL = wssh_pkg::crc_col(gi);
    assign crc_terms[gi] = crc_in[gi] ? COL : '0;
  end

  always_comb begin
    crc_out = '0;
    for (int i = 0; i < W; i++) begin
      crc_out = crc_out ^ crc_terms[i];
    end
  end

  assign mul_out = (base * wssh_pkg::FNV_PRIME) ^ item.word;
  assign fold    = cfg.use_crc_mode ? crc_out : mul_out;

  always_comb begin
    mid_nxt  = mid_r;
    run_nxt  = run_r;
    oval_nxt = oval_r && !out_ready;
    if (advance) begin
      if (item.last) begin
        mid_nxt  = 1'b0;
        run_nxt  = cfg.seed_value;
        oval_nxt = 1'b1;
      end else begin
        mid_nxt  = 1'b1;
        run_nxt  = fold;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r  <= 1'b0;
      run_r  <= wssh_pkg::SEED_RESET;
      oval_r <= 1'b0;
    end else begin
      mid_r  <= mid_nxt;
      run_r  <= run_nxt;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item.last) begin
      ohash_r <= fold;
    end
  end

  assign out_valid = oval_r;
  assign out_hash  = ohash_r;

endmodule

`default_nettype wire
